// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BCCI_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BCCI_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/bcci_pkg.sv =====
// ----------------------------------------------------------------------------
// bcci_pkg
// Shared constants, codes and control/status types of the interpreter.
// ----------------------------------------------------------------------------
package bcci_pkg;

	// sizes
	localparam int MAX_INSTR   = 15;
	localparam int PROG_DEPTH  = 16;
	localparam int PROG_AW     = 4;
	localparam int PROG_W      = 24;
	localparam int TOKEN_DEPTH = 64;
	localparam int TOK_AW      = 6;
	localparam int CELL_DEPTH  = 16;
	localparam int CELL_AW     = 4;
	localparam int STACK_DEPTH = 16;
	localparam int DEPTH_W     = 5;
	localparam int BYTE_W      = 8;
	localparam int DIV_STEPS   = 8;
	localparam int DIV_CNT_W   = 3;
	localparam int CFG_W       = 7;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 16;

	// configuration register indexes
	localparam logic [1:0] CFG_TOKEN_SIZE = 2'd0;
	localparam logic [1:0] CFG_CELL_SIZE  = 2'd1;
	localparam logic [1:0] CFG_PROG_LEN   = 2'd2;

	// reset values of configuration
	localparam logic [6:0] TSZ_RESET  = 7'd64;
	localparam logic [4:0] CSZ_RESET  = 5'd8;
	localparam logic [3:0] PLEN_RESET = 4'd0;

	// input word kinds
	localparam logic [1:0] KIND_PROG  = 2'd0;
	localparam logic [1:0] KIND_TOKEN = 2'd1;
	localparam logic [1:0] KIND_CELL  = 2'd2;

	// operand modes
	localparam logic [1:0] MODE_TOK   = 2'd0;
	localparam logic [1:0] MODE_IND   = 2'd1;
	localparam logic [1:0] MODE_CELL  = 2'd2;
	localparam logic [1:0] MODE_CONST = 2'd3;

	// opcodes
	localparam logic [3:0] OP_MOV   = 4'd0;
	localparam logic [3:0] OP_ADD   = 4'd1;
	localparam logic [3:0] OP_SUB   = 4'd2;
	localparam logic [3:0] OP_MUL   = 4'd3;
	localparam logic [3:0] OP_DIV   = 4'd4;
	localparam logic [3:0] OP_XOR   = 4'd5;
	localparam logic [3:0] OP_OR    = 4'd6;
	localparam logic [3:0] OP_AND   = 4'd7;
	localparam logic [3:0] OP_GT    = 4'd8;
	localparam logic [3:0] OP_GE    = 4'd9;
	localparam logic [3:0] OP_EQ    = 4'd10;
	localparam logic [3:0] OP_NE    = 4'd11;
	localparam logic [3:0] OP_LE    = 4'd12;
	localparam logic [3:0] OP_LT    = 4'd13;
	localparam logic [3:0] OP_ELSE  = 4'd14;
	localparam logic [3:0] OP_ENDIF = 4'd15;

	// divider operand selection
	typedef enum logic [2:0] {
		DV_DST_A,
		DV_DST_IND,
		DV_SRC_B,
		DV_SRC_IND,
		DV_CUR,
		DV_CELL_IDX
	} div_sel_t;

	// memory read address selection
	typedef enum logic [2:0] {
		RD_TOK_REM,
		RD_CELL_REM,
		RD_SRC_REM,
		RD_DST,
		RD_EMIT
	} rd_sel_t;

	// controller states
	typedef enum logic [4:0] {
		S_IDLE,
		S_RUN_INIT,
		S_FETCH,
		S_DECODE,
		S_DST_GO,
		S_DST_WAIT,
		S_DST_IDATA,
		S_DST_IWAIT,
		S_SRC_GO,
		S_SRC_WAIT,
		S_SRC_DATA,
		S_SRC_IWAIT,
		S_SRC_IDATA,
		S_CUR_RD,
		S_CUR_DATA,
		S_DIV_WAIT,
		S_WRITE,
		S_EMIT_RD,
		S_EMIT_LD,
		S_CR_GO,
		S_CR_WAIT,
		S_CR_LD
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic     in_cap;
		logic     run_init;
		logic     decode;
		logic     div_start;
		div_sel_t div_sel;
		rd_sel_t  rd_sel;
		logic     dst_ld;
		logic     src_ld_b;
		logic     src_ld_data;
		logic     cur_ld;
		logic     exec;
		logic     out_ld_tok;
		logic     out_ld_cell;
		logic     emit_inc;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] in_kind;
		logic       in_last;
		logic       m1_ind;
		logic       m2_const;
		logic       m2_ind;
		logic       is_div;
		logic       src_nz;
		logic       enabled;
		logic       div_busy;
		logic       div_done;
		logic       out_free;
		logic       emit_last;
		logic       pc_last;
		logic       plen_zero;
	} dp_sts_t;

endpackage

// ===== src/bcci_ram.sv =====
// ----------------------------------------------------------------------------
// bcci_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bcci_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/bcci_divider.sv =====
// ----------------------------------------------------------------------------
// bcci_divider
// Restoring 8-bit unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bcci_divider import bcci_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [BYTE_W-1:0] dividend,
	input  logic [BYTE_W-1:0] divisor,
	output logic [BYTE_W-1:0] quotient,
	output logic [BYTE_W-1:0] remainder,
	output logic              busy,
	output logic              done
);

	logic [BYTE_W-1:0]    rem_q;
	logic [BYTE_W-1:0]    quo_q;
	logic [BYTE_W-1:0]    dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [BYTE_W:0]      shifted;
	logic                 fits;

	// trial subtract
	assign shifted = {rem_q, quo_q[BYTE_W-1]};
	assign fits    = shifted >= {1'b0, dvs_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// partial remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? BYTE_W'(shifted - {1'b0, dvs_q}) : shifted[BYTE_W-1:0];
			quo_q <= {quo_q[BYTE_W-2:0], fits};
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign busy      = busy_q;
	assign done      = done_q;

endmodule

// ===== src/bcci_datapath.sv =====
// ----------------------------------------------------------------------------
// bcci_datapath
// Stores, address reduction, ALU, condition stack and output register.
// ----------------------------------------------------------------------------
module bcci_datapath import bcci_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_index,
	input  logic [CFG_W-1:0]       cfg_wdata,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic [1:0]             s_axis_tuser,
	input  logic                   s_axis_tlast,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	output logic                   m_axis_tuser,
	output logic                   m_axis_tlast,
	input  dp_cmd_t                cmd,
	output dp_sts_t                sts
);

	// input fields
	logic [5:0]        in_idx;
	logic [BYTE_W-1:0] in_val, in_op, in_a, in_b;
	assign in_idx = s_axis_tdata[5:0];
	assign in_val = s_axis_tdata[13:6];
	assign in_op  = s_axis_tdata[21:14];
	assign in_a   = s_axis_tdata[29:22];
	assign in_b   = s_axis_tdata[37:30];

	// configuration
	logic [6:0] tsz_q;
	logic [4:0] csz_q;
	logic [3:0] plen_q;
	logic [6:0] tsz_eff;
	logic [4:0] csz_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tsz_q  <= TSZ_RESET;
			csz_q  <= CSZ_RESET;
			plen_q <= PLEN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TOKEN_SIZE: tsz_q  <= cfg_wdata[6:0];
				CFG_CELL_SIZE:  csz_q  <= cfg_wdata[4:0];
				CFG_PROG_LEN:   plen_q <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	// clamp sizes to the store depths
	always_comb begin
		priority if (tsz_q == '0) tsz_eff = 7'd1;
		else if (tsz_q > 7'(TOKEN_DEPTH)) tsz_eff = 7'(TOKEN_DEPTH);
		else tsz_eff = tsz_q;
		priority if (csz_q == '0) csz_eff = 5'd1;
		else if (csz_q > 5'(CELL_DEPTH)) csz_eff = 5'(CELL_DEPTH);
		else csz_eff = csz_q;
	end

	// captured input index and decoded instruction
	logic [5:0]        idx_q;
	logic [3:0]        op_q;
	logic [1:0]        m1_q, m2_q;
	logic [BYTE_W-1:0] a_q, b_q;
	logic [PROG_W-1:0] prog_rdata;

	always_ff @(posedge clk) begin
		if (cmd.in_cap) begin
			idx_q <= in_idx;
		end
		if (cmd.decode) begin
			op_q <= prog_rdata[23:20];
			m1_q <= prog_rdata[19:18];
			m2_q <= prog_rdata[17:16];
			a_q  <= prog_rdata[15:8];
			b_q  <= prog_rdata[7:0];
		end
	end

	logic m1_ind, m1_cell, m2_ind, m2_cell, m2_const;
	assign m1_ind   = m1_q == MODE_IND;
	assign m1_cell  = m1_q == MODE_CELL;
	assign m2_ind   = m2_q == MODE_IND;
	assign m2_cell  = m2_q == MODE_CELL;
	assign m2_const = m2_q == MODE_CONST;

	// control counters and stack
	logic [PROG_AW-1:0]     pc_q;
	logic [TOK_AW-1:0]      emit_q;
	logic [STACK_DEPTH-1:0] stack_q;
	logic [DEPTH_W-1:0]     depth_q;
	logic [TOK_AW-1:0]      dst_q;
	logic                   dst_cell_q;
	logic [BYTE_W-1:0]      src_q, cur_q;

	// divider
	logic              div_busy, div_done;
	logic [BYTE_W-1:0] div_quo, div_rem, dvd, dvs;

	// memory read mux
	logic [TOK_AW-1:0] rd_addr;
	logic              rd_cell;
	logic              rd_cell_q, rd_tok_ok_q, rd_cell_ok_q;
	logic [BYTE_W-1:0] tok_rdata, cell_rdata, rd_data;
	logic [TOKEN_DEPTH-1:0] tok_vld_q;
	logic [CELL_DEPTH-1:0]  cell_vld_q;

	always_comb begin
		unique case (cmd.rd_sel)
			RD_TOK_REM: begin
				rd_addr = div_rem[TOK_AW-1:0];
				rd_cell = 1'b0;
			end
			RD_CELL_REM: begin
				rd_addr = {2'b00, div_rem[CELL_AW-1:0]};
				rd_cell = 1'b1;
			end
			RD_SRC_REM: begin
				rd_addr = m2_cell ? {2'b00, div_rem[CELL_AW-1:0]} : div_rem[TOK_AW-1:0];
				rd_cell = m2_cell;
			end
			RD_DST: begin
				rd_addr = dst_q;
				rd_cell = dst_cell_q;
			end
			RD_EMIT: begin
				rd_addr = emit_q;
				rd_cell = 1'b0;
			end
			default: begin
				rd_addr = emit_q;
				rd_cell = 1'b0;
			end
		endcase
	end

	// unwritten entries read as zero
	always_ff @(posedge clk) begin
		rd_cell_q    <= rd_cell;
		rd_tok_ok_q  <= tok_vld_q[rd_addr];
		rd_cell_ok_q <= cell_vld_q[rd_addr[CELL_AW-1:0]];
	end

	always_comb begin
		if (rd_cell_q) rd_data = rd_cell_ok_q ? cell_rdata : '0;
		else rd_data = rd_tok_ok_q ? tok_rdata : '0;
	end

	// divider operands
	logic [BYTE_W-1:0] tsz8, csz8, abs_cur;
	assign tsz8    = {1'b0, tsz_eff};
	assign csz8    = {3'b000, csz_eff};
	assign abs_cur = rd_data[BYTE_W-1] ? BYTE_W'(~rd_data + 8'd1) : rd_data;

	always_comb begin
		unique case (cmd.div_sel)
			DV_DST_A: begin
				dvd = a_q;
				dvs = m1_cell ? csz8 : tsz8;
			end
			DV_DST_IND: begin
				dvd = rd_data;
				dvs = tsz8;
			end
			DV_SRC_B: begin
				dvd = b_q;
				dvs = m2_cell ? csz8 : tsz8;
			end
			DV_SRC_IND: begin
				dvd = rd_data;
				dvs = tsz8;
			end
			DV_CUR: begin
				dvd = abs_cur;
				dvs = src_q;
			end
			DV_CELL_IDX: begin
				dvd = {2'b00, idx_q};
				dvs = csz8;
			end
			default: begin
				dvd = a_q;
				dvs = tsz8;
			end
		endcase
	end

	bcci_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (dvd),
		.divisor   (dvs),
		.quotient  (div_quo),
		.remainder (div_rem),
		.busy      (div_busy),
		.done      (div_done)
	);

	// operand registers
	always_ff @(posedge clk) begin
		if (cmd.dst_ld) begin
			dst_q      <= m1_cell ? {2'b00, div_rem[CELL_AW-1:0]} : div_rem[TOK_AW-1:0];
			dst_cell_q <= m1_cell;
		end
		if (cmd.src_ld_b) src_q <= b_q;
		else if (cmd.src_ld_data) src_q <= rd_data;
		if (cmd.cur_ld) cur_q <= rd_data;
	end

	// all stacked conditions true
	logic enabled;
	always_comb begin
		enabled = 1'b1;
		for (int k = 0; k < STACK_DEPTH; k++) begin
			if (DEPTH_W'(k) < depth_q && !stack_q[k]) enabled = 1'b0;
		end
	end

	// ALU
	logic [BYTE_W-1:0]   alu_r, quot_s, cur_eff;
	logic [2*BYTE_W-1:0] prod;
	logic                wr_en, cond;
	assign prod   = cur_q * src_q;
	assign quot_s = cur_q[BYTE_W-1] ? BYTE_W'(~div_quo + 8'd1) : div_quo;

	always_comb begin
		unique case (op_q)
			OP_MOV:  alu_r = src_q;
			OP_ADD:  alu_r = BYTE_W'(cur_q + src_q);
			OP_SUB:  alu_r = BYTE_W'(cur_q - src_q);
			OP_MUL:  alu_r = prod[BYTE_W-1:0];
			OP_DIV:  alu_r = (src_q == '0) ? '0 : quot_s;
			OP_XOR:  alu_r = cur_q ^ src_q;
			OP_OR:   alu_r = cur_q | src_q;
			OP_AND:  alu_r = cur_q & src_q;
			default: alu_r = cur_q;
		endcase
	end

	assign wr_en   = enabled && (op_q <= OP_AND);
	assign cur_eff = wr_en ? alu_r : cur_q;

	// unsigned compares
	always_comb begin
		unique case (op_q)
			OP_GT:   cond = cur_eff > src_q;
			OP_GE:   cond = cur_eff >= src_q;
			OP_EQ:   cond = cur_eff == src_q;
			OP_NE:   cond = cur_eff != src_q;
			OP_LE:   cond = cur_eff <= src_q;
			default: cond = cur_eff < src_q;
		endcase
	end

	// stack, program counter and emit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_q <= '0;
			depth_q <= '0;
			pc_q    <= '0;
			emit_q  <= '0;
		end else begin
			if (cmd.run_init) begin
				stack_q <= '0;
				depth_q <= '0;
				pc_q    <= '0;
				emit_q  <= '0;
			end
			if (cmd.emit_inc) emit_q <= emit_q + 1'b1;
			if (cmd.exec) begin
				pc_q <= pc_q + 1'b1;
				priority if (op_q >= OP_GT && op_q <= OP_LT) begin
					if (depth_q < DEPTH_W'(STACK_DEPTH)) begin
						stack_q[depth_q[CELL_AW-1:0]] <= cond;
						depth_q <= depth_q + 1'b1;
					end
				end else if (op_q == OP_ELSE) begin
					if (depth_q != '0) begin
						stack_q[CELL_AW'(depth_q - 1'b1)] <= ~stack_q[CELL_AW'(depth_q - 1'b1)];
					end
				end else if (op_q == OP_ENDIF) begin
					if (depth_q != '0) depth_q <= depth_q - 1'b1;
				end else begin
					// arithmetic ops leave the stack alone
				end
			end
		end
	end

	// store writes
	logic prog_we, tok_we, cell_we;
	logic [TOK_AW-1:0] tok_waddr;
	logic [BYTE_W-1:0] tok_wdata;
	assign prog_we   = cmd.in_cap && s_axis_tuser == KIND_PROG && in_idx < 6'(MAX_INSTR);
	assign tok_we    = (cmd.in_cap && s_axis_tuser == KIND_TOKEN)
	                   || (cmd.exec && wr_en && !dst_cell_q);
	assign cell_we   = cmd.exec && wr_en && dst_cell_q;
	assign tok_waddr = cmd.in_cap ? in_idx : dst_q;
	assign tok_wdata = cmd.in_cap ? in_val : alu_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_vld_q  <= '0;
			cell_vld_q <= '0;
		end else begin
			if (tok_we) tok_vld_q[tok_waddr] <= 1'b1;
			if (cell_we) cell_vld_q[dst_q[CELL_AW-1:0]] <= 1'b1;
		end
	end

	bcci_ram #(.WIDTH(PROG_W), .DEPTH(PROG_DEPTH)) u_prog_ram (
		.clk   (clk),
		.we    (prog_we),
		.waddr (in_idx[PROG_AW-1:0]),
		.wdata ({in_op, in_a, in_b}),
		.raddr (pc_q),
		.rdata (prog_rdata)
	);

	bcci_ram #(.WIDTH(BYTE_W), .DEPTH(TOKEN_DEPTH)) u_tok_ram (
		.clk   (clk),
		.we    (tok_we),
		.waddr (tok_waddr),
		.wdata (tok_wdata),
		.raddr (rd_addr),
		.rdata (tok_rdata)
	);

	bcci_ram #(.WIDTH(BYTE_W), .DEPTH(CELL_DEPTH)) u_cell_ram (
		.clk   (clk),
		.we    (cell_we),
		.waddr (dst_q[CELL_AW-1:0]),
		.wdata (alu_r),
		.raddr (rd_addr[CELL_AW-1:0]),
		.rdata (cell_rdata)
	);

	// output register
	logic              out_valid_q, out_cell_q, out_last_q;
	logic [BYTE_W-1:0] out_data_q;
	logic [5:0]        out_pos_q;
	logic              out_free, emit_last;
	assign out_free  = !out_valid_q || m_axis_tready;
	assign emit_last = ({1'b0, emit_q} + 7'd1) == tsz_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld_tok || cmd.out_ld_cell) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld_tok) begin
			out_data_q <= rd_data;
			out_pos_q  <= emit_q;
			out_cell_q <= 1'b0;
			out_last_q <= emit_last;
		end else if (cmd.out_ld_cell) begin
			out_data_q <= rd_data;
			out_pos_q  <= {2'b00, div_rem[CELL_AW-1:0]};
			out_cell_q <= 1'b1;
			out_last_q <= 1'b1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_pos_q, out_data_q};
	assign m_axis_tuser  = out_cell_q;
	assign m_axis_tlast  = out_last_q;

	// status
	always_comb begin
		sts.in_kind   = s_axis_tuser;
		sts.in_last   = s_axis_tlast;
		sts.m1_ind    = m1_ind;
		sts.m2_const  = m2_const;
		sts.m2_ind    = m2_ind;
		sts.is_div    = op_q == OP_DIV;
		sts.src_nz    = src_q != '0;
		sts.enabled   = enabled;
		sts.div_busy  = div_busy;
		sts.div_done  = div_done;
		sts.out_free  = out_free;
		sts.emit_last = emit_last;
		sts.pc_last   = ({1'b0, pc_q} + 5'd1) == {1'b0, plen_q};
		sts.plen_zero = plen_q == '0;
	end

endmodule

// ===== src/bcci_control.sv =====
// ----------------------------------------------------------------------------
// bcci_control
// Sequencer: loads, instruction walk, byte emission and cell reads.
// ----------------------------------------------------------------------------
module bcci_control import bcci_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_axis_tvalid,
	output logic    s_axis_tready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) begin
					if (sts.in_kind == KIND_TOKEN && sts.in_last) state_d = S_RUN_INIT;
					else if (sts.in_kind == KIND_CELL) state_d = S_CR_GO;
				end
			end
			S_RUN_INIT:  state_d = sts.plen_zero ? S_EMIT_RD : S_FETCH;
			S_FETCH:     state_d = S_DECODE;
			S_DECODE:    state_d = S_DST_GO;
			S_DST_GO:    state_d = S_DST_WAIT;
			S_DST_WAIT: begin
				if (sts.div_done) state_d = sts.m1_ind ? S_DST_IDATA : S_SRC_GO;
			end
			S_DST_IDATA: state_d = S_DST_IWAIT;
			S_DST_IWAIT: begin
				if (sts.div_done) state_d = S_SRC_GO;
			end
			S_SRC_GO:    state_d = sts.m2_const ? S_CUR_RD : S_SRC_WAIT;
			S_SRC_WAIT: begin
				if (sts.div_done) state_d = S_SRC_DATA;
			end
			S_SRC_DATA:  state_d = sts.m2_ind ? S_SRC_IWAIT : S_CUR_RD;
			S_SRC_IWAIT: begin
				if (sts.div_done) state_d = S_SRC_IDATA;
			end
			S_SRC_IDATA: state_d = S_CUR_RD;
			S_CUR_RD:    state_d = S_CUR_DATA;
			S_CUR_DATA: begin
				if (sts.is_div && sts.src_nz && sts.enabled) state_d = S_DIV_WAIT;
				else state_d = S_WRITE;
			end
			S_DIV_WAIT: begin
				if (sts.div_done) state_d = S_WRITE;
			end
			S_WRITE:     state_d = sts.pc_last ? S_EMIT_RD : S_FETCH;
			S_EMIT_RD:   state_d = S_EMIT_LD;
			S_EMIT_LD: begin
				if (sts.out_free) state_d = sts.emit_last ? S_IDLE : S_EMIT_RD;
			end
			S_CR_GO:     state_d = S_CR_WAIT;
			S_CR_WAIT: begin
				if (sts.div_done) state_d = S_CR_LD;
			end
			S_CR_LD: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default:     state_d = S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd           = '0;
		cmd.div_sel   = DV_DST_A;
		cmd.rd_sel    = RD_EMIT;
		s_axis_tready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_axis_tready = 1'b1;
				cmd.in_cap    = s_axis_tvalid;
			end
			S_RUN_INIT:  cmd.run_init = 1'b1;
			S_FETCH:     ;
			S_DECODE:    cmd.decode = 1'b1;
			S_DST_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DV_DST_A;
			end
			S_DST_WAIT: begin
				cmd.rd_sel = RD_TOK_REM;
				cmd.dst_ld = sts.div_done && !sts.m1_ind;
			end
			S_DST_IDATA: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DV_DST_IND;
			end
			S_DST_IWAIT: cmd.dst_ld = sts.div_done;
			S_SRC_GO: begin
				cmd.src_ld_b  = sts.m2_const;
				cmd.div_start = !sts.m2_const;
				cmd.div_sel   = DV_SRC_B;
			end
			S_SRC_WAIT:  cmd.rd_sel = RD_SRC_REM;
			S_SRC_DATA: begin
				cmd.src_ld_data = !sts.m2_ind;
				cmd.div_start   = sts.m2_ind;
				cmd.div_sel     = DV_SRC_IND;
			end
			S_SRC_IWAIT: cmd.rd_sel = RD_TOK_REM;
			S_SRC_IDATA: cmd.src_ld_data = 1'b1;
			S_CUR_RD:    cmd.rd_sel = RD_DST;
			S_CUR_DATA: begin
				cmd.cur_ld    = 1'b1;
				cmd.div_start = sts.is_div && sts.src_nz && sts.enabled;
				cmd.div_sel   = DV_CUR;
			end
			S_DIV_WAIT:  ;
			S_WRITE:     cmd.exec = 1'b1;
			S_EMIT_RD:   cmd.rd_sel = RD_EMIT;
			S_EMIT_LD: begin
				cmd.rd_sel     = RD_EMIT;
				cmd.out_ld_tok = sts.out_free;
				cmd.emit_inc   = sts.out_free && !sts.emit_last;
			end
			S_CR_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DV_CELL_IDX;
			end
			S_CR_WAIT:   cmd.rd_sel = RD_CELL_REM;
			S_CR_LD: begin
				cmd.rd_sel      = RD_CELL_REM;
				cmd.out_ld_cell = sts.out_free;
			end
			default:     ;
		endcase
	end

endmodule

// ===== src/byte_code_cell_interpreter.sv =====
// ----------------------------------------------------------------------------
// byte_code_cell_interpreter
// Byte-code interpreter over a token store and a persistent cell store.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one word per item. tuser is the kind (load instruction, token
//   byte, read cell byte); tlast on a token byte starts a program run.
//   m_axis: result bytes. tuser flags a cell byte, tlast marks the final
//   byte of a result run.
//   cfg_we/cfg_index/cfg_wdata write token_size, cell_size, program_length
//   while the block is idle.
// Flow: s_axis_tready is high only while the sequencer is idle; a load
//   leaves it idle, while a cell read or a run holds it until done. A cell
//   read reduces the index through the divider, then reads the cell store.
//   A run has a start step, then walks each instruction through the shared
//   8-step divider that reduces every operand address (and performs div),
//   then emits token bytes through the single token store read port.
// Reset: token and cell stores read as zero, configuration returns to
//   64 / 8 / 0; program slots hold nothing until loaded.
// Stall: a held output word stalls the sequencer; no word is dropped.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module byte_code_cell_interpreter import bcci_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_index,
	input  logic [CFG_W-1:0]       cfg_wdata,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// index[5:0], value[13:6], op_byte[21:14], operand_a[29:22], operand_b[37:30]
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// kind[1:0]
	input  logic [1:0]             s_axis_tuser,
	input  logic                   s_axis_tlast,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// data[7:0], position[13:8]
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// from_cell[0]
	output logic                   m_axis_tuser,
	output logic                   m_axis_tlast
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	bcci_control u_ctl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.sts           (sts),
		.cmd           (cmd)
	);

	bcci_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cmd           (cmd),
		.sts           (sts)
	);

	// checks
	`BCCI_ASSERT_IMP(a_out_no_overwrite, cmd.out_ld_tok || cmd.out_ld_cell, sts.out_free, "output word overwritten")
	`BCCI_ASSERT_IMP(a_div_start_idle, cmd.div_start, !sts.div_busy, "divider restarted while busy")
	`BCCI_ASSERT_NXT(a_cell_read_holds, s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_CELL, !s_axis_tready, "input taken during cell read")

endmodule
